[sv/qpsm_pkg.sv]
// Shared widths, codes and transaction types for the quadrature period speed meter.
// No dependencies; every other file imports this package.
package qpsm_pkg;

  localparam int unsigned CountWidth  = 16;
  localparam int unsigned PeriodW     = CountWidth + 1;
  localparam int unsigned PprW        = 12;
  localparam int unsigned LimitW      = 16;
  localparam int unsigned RateW       = 16;
  localparam int unsigned FracBits    = 16;
  localparam int unsigned SpeedW      = 32;
  localparam int unsigned NumW        = RateW + FracBits;
  localparam int unsigned DenW        = PprW + CountWidth + 2;
  localparam int unsigned DivCntW     = $clog2(NumW);
  localparam int unsigned WindowDepth = 4;
  localparam int unsigned WinShift    = $clog2(WindowDepth);
  localparam int unsigned SumW        = SpeedW + WinShift;
  localparam int unsigned QueueDepth  = 2;
  localparam int unsigned QPtrW       = $clog2(QueueDepth);
  localparam int unsigned QCntW       = $clog2(QueueDepth + 1);
  localparam int unsigned CfgIdxW     = 2;
  localparam int unsigned CfgDataW    = 16;

  localparam logic [CfgIdxW-1:0] CfgPulsesPerRev = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgStallLimit   = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgTickRateHz   = 2'd2;

  localparam logic [PprW-1:0]   PprReset   = 12'd120;
  localparam logic [LimitW-1:0] LimitReset = 16'd50;
  localparam logic [RateW-1:0]  RateReset  = 16'd1000;

  typedef enum logic [1:0] {
    DirCcw  = 2'd0,
    DirCw   = 2'd1,
    DirZero = 2'd2
  } dir_e;

  typedef struct packed {
    logic [PprW-1:0]   pulses_per_rev;
    logic [LimitW-1:0] stall_limit;
    logic [RateW-1:0]  tick_rate_hz;
  } cfg_t;

  // One report transaction handed from front end to back end
  typedef struct packed {
    logic                  stopped;
    dir_e                  dir;
    logic [CountWidth-1:0] mag;
  } job_t;

endpackage

[sv/qpsm_front.sv]
// Tick front end: edge detection, saturating period counter, stopped flag.
// Classifies each tick and pushes report transactions to the queue. Uses qpsm_pkg.
module qpsm_front (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic                        a_level_i,
  input  logic                        b_level_i,
  input  logic                        report_i,
  input  logic [qpsm_pkg::LimitW-1:0] stall_limit_i,
  input  logic                        queue_full_i,
  output logic                        push_o,
  output qpsm_pkg::job_t              job_o
);
  import qpsm_pkg::*;

  logic                  prev_a_q, prev_b_q;
  logic [CountWidth-1:0] count_q, count_d, count_b;
  logic [PeriodW-1:0]    period_q, period_d, period_neg;
  logic                  stopped_q, stopped_d;
  logic                  accept, a_edge, b_edge, both;

  assign in_stall_o = queue_full_i;
  assign accept     = in_valid_i & ~in_stall_o;
  assign a_edge     = a_level_i ^ prev_a_q;
  assign b_edge     = b_level_i ^ prev_b_q;
  assign both       = a_level_i & b_level_i;

  // A is handled first: a B capture in the same tick sees a cleared count
  assign count_b    = a_edge ? '0 : count_q;
  assign period_neg = PeriodW'(0) - {1'b0, count_b};

  always_comb begin
    period_d  = period_q;
    stopped_d = stopped_q;
    if (a_edge && both) begin
      period_d = {1'b0, count_q};
    end
    if (b_edge && both) begin
      period_d = period_neg;
    end
    if (a_edge || b_edge) begin
      count_d   = '0;
      stopped_d = 1'b0;
    end else if (count_q != '1) begin
      count_d = count_q + 1'b1;
    end else begin
      count_d = count_q;
    end
    if (report_i && (count_d > CountWidth'(stall_limit_i))) begin
      stopped_d = 1'b1;
    end
  end

  always_comb begin
    job_o.stopped = stopped_d;
    if (period_d[PeriodW-1]) begin
      job_o.dir = DirCw;
      job_o.mag = CountWidth'(PeriodW'(0) - period_d);
    end else begin
      job_o.dir = (period_d == '0) ? DirZero : DirCcw;
      job_o.mag = period_d[CountWidth-1:0];
    end
  end

  assign push_o = accept & report_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_a_q  <= 1'b0;
      prev_b_q  <= 1'b0;
      count_q   <= '0;
      period_q  <= '0;
      stopped_q <= 1'b1;
    end else if (accept) begin
      prev_a_q  <= a_level_i;
      prev_b_q  <= b_level_i;
      count_q   <= count_d;
      period_q  <= period_d;
      stopped_q <= stopped_d;
    end
  end

endmodule

[sv/qpsm_fifo.sv]
// Short transaction queue between front end and back end.
// Register storage, one read port at the head. Uses qpsm_pkg.
module qpsm_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  qpsm_pkg::job_t push_data_i,
  input  logic           pop_i,
  output qpsm_pkg::job_t pop_data_o,
  output logic           full_o,
  output logic           empty_o
);
  import qpsm_pkg::*;

  job_t             entry_q [QueueDepth];
  logic [QPtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCntW-1:0] fill_q;
  logic             do_push, do_pop;

  assign full_o     = (fill_q == QCntW'(QueueDepth));
  assign empty_o    = (fill_q == '0);
  assign do_push    = push_i & ~full_o;
  assign do_pop     = pop_i & ~empty_o;
  assign pop_data_o = entry_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == QPtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == QPtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   fill_q <= fill_q + 1'b1;
        2'b01:   fill_q <= fill_q - 1'b1;
        default: fill_q <= fill_q;
      endcase
    end
  end

endmodule

[sv/qpsm_back.sv]
// Report back end: period-to-speed conversion (multiply, bit-serial divide),
// four-entry averaging window and output register. Uses qpsm_pkg.
module qpsm_back (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  qpsm_pkg::cfg_t            cfg_i,
  input  logic                      queue_empty_i,
  input  qpsm_pkg::job_t            job_i,
  output logic                      pop_o,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic [1:0]                direction_o,
  output logic [qpsm_pkg::SpeedW-1:0] speed_rps_o,
  output logic                      is_stopped_o
);
  import qpsm_pkg::*;

  typedef enum logic [4:0] {
    StIdle = 5'b00001,
    StMul  = 5'b00010,
    StDiv  = 5'b00100,
    StAvg  = 5'b01000,
    StPush = 5'b10000
  } state_e;

  state_e             state_q, state_d;
  job_t               job_q;
  logic [DenW-1:0]    den_q;
  logic [DenW-1:0]    rem_q;
  logic [NumW-1:0]    quo_q;
  logic [DivCntW-1:0] cnt_q;
  logic [SpeedW-1:0]  win_q [WindowDepth];
  logic [SpeedW-1:0]  win_d [WindowDepth];
  logic [SpeedW-1:0]  last_avg_q;
  logic [SpeedW-1:0]  res_speed_q;
  logic               out_valid_q;
  dir_e               out_dir_q;
  logic [SpeedW-1:0]  out_speed_q;
  logic               out_stopped_q;
  logic [DenW:0]      rem_shift;
  logic               rem_ge;
  logic [SumW-1:0]    win_sum;
  logic               out_free;

  assign out_free = ~out_valid_q | ~out_stall_i;
  assign pop_o    = (state_q == StIdle) & ~queue_empty_i;

  // Restoring divide, one quotient bit a cycle. A zero divisor yields all ones,
  // which is the saturated sample.
  assign rem_shift = {rem_q, quo_q[NumW-1]};
  assign rem_ge    = (rem_shift >= {1'b0, den_q});

  always_comb begin
    win_sum = '0;
    for (int i = 0; i < WindowDepth; i++) begin
      if (last_avg_q == '0 || i == WindowDepth - 1) begin
        win_d[i] = quo_q;
      end else begin
        win_d[i] = win_q[i+1];
      end
      win_sum = win_sum + SumW'(win_d[i]);
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: begin
        if (!queue_empty_i) begin
          state_d = job_i.stopped ? StPush : StMul;
        end
      end
      StMul:  state_d = StDiv;
      StDiv:  state_d = (cnt_q == '0) ? StAvg : StDiv;
      StAvg:  state_d = StPush;
      StPush: state_d = out_free ? StIdle : StPush;
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      StIdle: begin
        job_q       <= job_i;
        res_speed_q <= '0;
      end
      StMul: begin
        den_q <= {(DenW-2)'(cfg_i.pulses_per_rev) * (DenW-2)'(job_q.mag), 2'b00};
        rem_q <= '0;
        quo_q <= {cfg_i.tick_rate_hz, FracBits'(0)};
        cnt_q <= DivCntW'(NumW - 1);
      end
      StDiv: begin
        rem_q <= rem_ge ? DenW'(rem_shift - {1'b0, den_q}) : rem_shift[DenW-1:0];
        quo_q <= {quo_q[NumW-2:0], rem_ge};
        cnt_q <= cnt_q - 1'b1;
      end
      StAvg: begin
        res_speed_q <= win_sum[SumW-1:WinShift];
      end
      StPush: begin
        if (out_free) begin
          out_dir_q     <= job_q.dir;
          out_speed_q   <= res_speed_q;
          out_stopped_q <= job_q.stopped;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
      last_avg_q  <= '0;
      for (int i = 0; i < WindowDepth; i++) begin
        win_q[i] <= '0;
      end
    end else begin
      state_q <= state_d;
      if (state_q == StPush && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (pop_o && job_i.stopped) begin
        last_avg_q <= '0;
      end else if (state_q == StAvg) begin
        last_avg_q <= win_sum[SumW-1:WinShift];
        for (int i = 0; i < WindowDepth; i++) begin
          win_q[i] <= win_d[i];
        end
      end
    end
  end

  assign out_valid_o  = out_valid_q;
  assign direction_o  = out_dir_q;
  assign speed_rps_o  = out_speed_q;
  assign is_stopped_o = out_stopped_q;

endmodule

[sv/quadrature_period_speed_meter.sv]
// Top level of the quadrature period speed meter: configuration registers,
// front end, transaction queue and back end. Uses qpsm_pkg, qpsm_front, qpsm_fifo, qpsm_back.
//
//  channel  | handshake              | payload
//  ---------+------------------------+-----------------------------------------
//  in       | in_valid_i/in_stall_o  | a_level_i, b_level_i, report_i
//  out      | out_valid_o/out_stall_i| direction_o, speed_rps_o, is_stopped_o
//  cfg      | cfg_valid_i/cfg_ready_o| cfg_index_i, cfg_data_i
//
// Ticks are taken one a cycle while the two-entry report queue has room.
// A report passes through the back end as one multiply, 32 divide steps, averaging
// and output load; a stopped report goes straight to the output load.
// Reset restores the register defaults, marks the motor stopped and clears the window.
// in_stall_o rises only while the queue is full; a stalled output holds the back end.
module quadrature_period_speed_meter (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic                         a_level_i,
  input  logic                         b_level_i,
  input  logic                         report_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [1:0]                   direction_o,
  output logic [31:0]                  speed_rps_o,
  output logic                         is_stopped_o,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [qpsm_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [qpsm_pkg::CfgDataW-1:0] cfg_data_i
);
  import qpsm_pkg::*;

  cfg_t cfg_q;
  logic push, pop, q_full, q_empty;
  job_t push_job, pop_job;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.pulses_per_rev <= PprReset;
      cfg_q.stall_limit    <= LimitReset;
      cfg_q.tick_rate_hz   <= RateReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CfgPulsesPerRev: cfg_q.pulses_per_rev <= cfg_data_i[PprW-1:0];
        CfgStallLimit:   cfg_q.stall_limit    <= cfg_data_i[LimitW-1:0];
        CfgTickRateHz:   cfg_q.tick_rate_hz   <= cfg_data_i[RateW-1:0];
        default: ;
      endcase
    end
  end

  qpsm_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .a_level_i     (a_level_i),
    .b_level_i     (b_level_i),
    .report_i      (report_i),
    .stall_limit_i (cfg_q.stall_limit),
    .queue_full_i  (q_full),
    .push_o        (push),
    .job_o         (push_job)
  );

  qpsm_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_job),
    .pop_i       (pop),
    .pop_data_o  (pop_job),
    .full_o      (q_full),
    .empty_o     (q_empty)
  );

  qpsm_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .queue_empty_i (q_empty),
    .job_i         (pop_job),
    .pop_o         (pop),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .direction_o   (direction_o),
    .speed_rps_o   (speed_rps_o),
    .is_stopped_o  (is_stopped_o)
  );

  a_stopped_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && is_stopped_o |-> speed_rps_o == '0)
    else $error("stopped result carries nonzero speed");

  a_push_needs_report: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> in_valid_i && report_i)
    else $error("queue push without an accepted report");

  a_push_not_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> !q_full)
    else $error("push into a full report queue");

  a_pop_not_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> !q_empty)
    else $error("back end popped an empty queue");

endmodule
